// ===== hw/rtl/touch_pad_scan_chord_report_core_assert.svh =====
// Assertion macros for the touch pad scanner checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TOUCH_PAD_SCAN_CHORD_REPORT_CORE_ASSERT_SVH
`define TOUCH_PAD_SCAN_CHORD_REPORT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define TPSCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch pad scanner: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define TPSCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch pad scanner: next-cycle check failed");

`endif

// ===== hw/rtl/tpscr_pkg.sv =====
// Shared types and constants of the touch pad scanner with chord reporting.
// No dependencies; used by the core and by its checker.
package tpscr_pkg;

  // Default parameter values
  localparam int unsigned NumPadsDefault    = 12;
  localparam int unsigned CountWidthDefault = 16;

  // Fixed field widths
  localparam int unsigned MaskW = 12;
  localparam int unsigned ChanW = 4;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [CfgW-1:0] PressThresholdReset = 16'd200;
  localparam logic [CfgW-1:0] RelaxTicksReset     = 16'd1000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegPressThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRelaxTicks     = 2'd1;

  // Scan phase, one-hot
  typedef enum logic [1:0] {
    PH_DISCHARGE = 2'b01,
    PH_CHARGE    = 2'b10
  } phase_e;

  // One result transaction
  typedef struct packed {
    logic             pad_drive;
    logic [ChanW-1:0] channel_select;
    logic             report_valid;
    logic [MaskW-1:0] report_mask;
  } result_t;

endpackage

// ===== hw/rtl/touch_pad_scan_chord_report_core.sv =====
// Touch pad scanner core: RC charge-time measurement over the pads and
// chord reporting. Depends on tpscr_pkg.
//
// Usage:
//   Each input transaction is one prescaled timer tick carrying the
//   comparator rising-edge flag. Each tick yields exactly one result
//   transaction: the charge pin level, the pad routed to the comparator,
//   and a chord report (report_valid, report_mask) when a frame with no
//   pressed pad follows frames that held pressed pads.
//   Throughput: one tick per clock cycle. The whole scan state update is
//   combinational logic from the state registers, so a tick is taken on
//   every cycle the input is valid and not stalled.
//   Output: the result is registered, in the output register, or in the
//   skid register while the output register holds a stalled result.
//   Stall: results go through a two-entry output buffer (output register
//   plus skid register). A tick is still taken while one result waits;
//   in_stall_o rises only when both entries are full.
//   Reset: the registers return to press threshold 200 and relax 1000
//   ticks; scanning starts by relaxing pad 0 and then charging it.
//   Configuration writes are applied at once and should only be issued
//   while no results are outstanding.
module touch_pad_scan_chord_report_core
  import tpscr_pkg::*;
#(
  parameter int unsigned NUM_PADS    = NumPadsDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // tick input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               comparator_edge_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pad_drive_o,
  output logic [ChanW-1:0]   channel_select_o,
  output logic               report_valid_o,
  output logic [MaskW-1:0]   report_mask_o
);

  localparam int unsigned PadIdxW = $clog2(NUM_PADS + 1);
  localparam int unsigned CmpW    = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;

  // Registers
  logic [CfgW-1:0]        thr_q, relax_q;
  phase_e                 phase_q, phase_d;
  logic [PadIdxW-1:0]     pad_q, pad_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [MaskW-1:0]       frame_q, frame_d;
  logic [MaskW-1:0]       held_q, held_d;

  logic                   out_valid_q, skid_valid_q;
  result_t                out_q, skid_q;

  // Combinational
  logic                   in_acc, out_fire;
  logic [COUNT_WIDTH-1:0] count;
  logic                   count_sat, thr_hit, relax_done;
  logic [MaskW-1:0]       pad_bit;
  logic [PadIdxW-1:0]     chan;
  logic                   rep;
  logic [MaskW-1:0]       rmask;
  result_t                res;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  // Saturating charge/relax count for this tick
  assign count_sat  = &tick_q;
  assign count      = count_sat ? tick_q : tick_q + 1'b1;
  assign thr_hit    = CmpW'(count) >= CmpW'(thr_q);
  assign relax_done = (CmpW'(count) >= CmpW'(relax_q)) || (&count);
  // Shifting past the mask leaves zero, so pads twelve and up set nothing
  assign pad_bit    = MaskW'(1) << pad_q;

  // Advance the scan by one tick
  always_comb begin
    phase_d = phase_q;
    pad_d   = pad_q;
    tick_d  = tick_q;
    frame_d = frame_q;
    held_d  = held_q;
    rep     = 1'b0;
    rmask   = '0;
    unique case (phase_q)
      PH_CHARGE: begin
        if (comparator_edge_i) begin
          if (thr_hit) frame_d = frame_q | pad_bit;
          if (pad_q < PadIdxW'(NUM_PADS)) pad_d = pad_q + 1'b1;
          phase_d = PH_DISCHARGE;
          tick_d  = '0;
        end else begin
          tick_d = count;
        end
      end
      PH_DISCHARGE: begin
        if (relax_done) begin
          // End the frame after the relax that follows the last pad
          if (pad_q >= PadIdxW'(NUM_PADS)) begin
            if (frame_q != '0) begin
              held_d = held_q | frame_q;
            end else if (held_q != '0) begin
              rep    = 1'b1;
              rmask  = held_q;
              held_d = '0;
            end
            frame_d = '0;
            pad_d   = '0;
          end
          phase_d = PH_CHARGE;
          tick_d  = '0;
        end else begin
          tick_d = count;
        end
      end
      default: begin
        phase_d = PH_DISCHARGE;
      end
    endcase
  end

  // Build the result from the updated state
  assign chan = (pad_d < PadIdxW'(NUM_PADS)) ? pad_d : PadIdxW'(NUM_PADS - 1);

  always_comb begin
    res.pad_drive      = (phase_d == PH_CHARGE);
    res.channel_select = ChanW'(chan);
    res.report_valid   = rep;
    res.report_mask    = rmask;
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= PressThresholdReset;
      relax_q <= RelaxTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPressThreshold: thr_q   <= cfg_data_i;
        RegRelaxTicks:     relax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Update scan state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DISCHARGE;
      pad_q   <= '0;
      tick_q  <= '0;
      frame_q <= '0;
      held_q  <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      pad_q   <= pad_d;
      tick_q  <= tick_d;
      frame_q <= frame_d;
      held_q  <= held_d;
    end
  end

  // Output register and skid entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register and skid entry payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_acc) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign pad_drive_o      = out_q.pad_drive;
  assign channel_select_o = out_q.channel_select;
  assign report_valid_o   = out_q.report_valid;
  assign report_mask_o    = out_q.report_mask;

endmodule

// ===== hw/rtl/tpscr_checker.sv =====
// Port-level checker for the touch pad scanner core, bound to each core instance.
// Depends on tpscr_pkg and touch_pad_scan_chord_report_core_assert.svh.
`include "touch_pad_scan_chord_report_core_assert.svh"

module tpscr_checker
  import tpscr_pkg::*;
#(
  parameter int unsigned NUM_PADS = NumPadsDefault
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               pad_drive_o,
  input logic [ChanW-1:0]   channel_select_o,
  input logic               report_valid_o,
  input logic [MaskW-1:0]   report_mask_o
);

  logic [ChanW+MaskW+1:0] out_payload;
  logic                   report_at_start;

  // Gather the result payload and the frame start view of a report
  assign out_payload     = {pad_drive_o, channel_select_o, report_valid_o, report_mask_o};
  assign report_at_start = pad_drive_o && (channel_select_o == '0) && (report_mask_o != '0);

  // A stalled result transaction stays offered
  `TPSCR_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result transaction keeps its payload
  `TPSCR_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i, $stable(out_payload))

  // Without a report the mask is zero
  `TPSCR_ASSERT_NOW(a_mask_zero_no_report, out_valid_o && !report_valid_o, report_mask_o == '0)

  // A report ends a frame: the scan has just restarted charging pad 0
  `TPSCR_ASSERT_NOW(a_report_at_frame_start, out_valid_o && report_valid_o, report_at_start)

  // The routed channel always names an existing pad
  `TPSCR_ASSERT_NOW(a_channel_in_range, out_valid_o, 32'(channel_select_o) < NUM_PADS)

endmodule

bind touch_pad_scan_chord_report_core tpscr_checker #(.NUM_PADS(NUM_PADS)) u_tpscr_checker (.*);
